// ===== hw/rtl/insertion_sort_ascending_macros.svh =====
// Assertion macros used by the checker of the sorter.
`ifndef INSERTION_SORT_ASCENDING_MACROS_SVH
`define INSERTION_SORT_ASCENDING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed");

`endif

// ===== hw/rtl/iss_pkg.sv =====
package iss_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;

    typedef struct packed {
        logic insert;
        logic drain;
    } iss_ctrl_t;

endpackage

// ===== hw/rtl/iss_stream_if.sv =====
interface iss_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [iss_pkg::DATA_W-1:0] value;
    logic                              last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface iss_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [iss_pkg::DATA_W-1:0] sorted_value;
    logic                              last_result;
    logic                              overflow;

    modport source (output valid, output sorted_value, output last_result, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_result, input overflow,
                    output ready);
endinterface

// ===== hw/rtl/insertion_sort_ascending.sv =====
// Ascending insertion sorter for signed 32-bit values.
// Items arrive on the items channel (value, last_item); a transaction is taken
// at a clock edge where valid and ready are both high. Each value is inserted
// into a chain of CAPACITY cells that compare it in parallel, so items are
// accepted back to back, one per cycle, while the list is filling.
// The transaction with last_item set is inserted too if a cell is free, and then
// the chain drains through the results channel, one transaction per cycle while
// results.ready is high, from cell 0 upward, in ascending order, with
// last_result on the final one. Equal values leave in their arrival order.
// The first result is offered the cycle after the last item is taken.
// While a run drains, items.ready is low. A stall on the results channel
// holds the current result and the whole chain until it is taken.
// Values that arrive while all cells are full are dropped, and overflow is
// reported on every result of that run; the flag clears with the run.
// Reset empties the chain and clears the overflow flag at once.
module insertion_sort_ascending (
    input  logic         clk,
    input  logic         rst_n,
    iss_in_if.sink       items,
    iss_out_if.source    results
);

    localparam int CAP = iss_pkg::CAPACITY;

    logic signed [iss_pkg::DATA_W-1:0] cell_value [CAP];
    logic                              cell_valid [CAP];
    logic                              cell_gt    [CAP];

    iss_pkg::iss_ctrl_t ctrl;
    logic               in_accept;
    logic               out_accept;
    logic               draining_reg;
    logic               draining_next;
    logic               overflow_reg;
    logic               overflow_next;

    assign in_accept  = items.valid && items.ready;
    assign out_accept = results.valid && results.ready;

    assign ctrl.insert = in_accept && !cell_valid[CAP-1];
    assign ctrl.drain  = out_accept;

    genvar i;
    generate
        for (i = 0; i < CAP; i++)
        begin : g_cell
            logic signed [iss_pkg::DATA_W-1:0] prev_value;
            logic                              prev_valid;
            logic                              prev_gt;
            logic signed [iss_pkg::DATA_W-1:0] next_value;
            logic                              next_valid;

            if (i == 0)
            begin : g_head
                assign prev_value = '0;
                assign prev_valid = 1'b0;
                assign prev_gt    = 1'b0;
            end
            else
            begin : g_body
                assign prev_value = cell_value[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_gt    = cell_gt[i-1];
            end

            if (i == CAP - 1)
            begin : g_tail
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_value = cell_value[i+1];
                assign next_valid = cell_valid[i+1];
            end

            iss_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (items.value),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_gt    (prev_gt),
                .next_value (next_value),
                .next_valid (next_valid),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        draining_next = draining_reg;
        overflow_next = overflow_reg;
        if (in_accept)
        begin
            if (cell_valid[CAP-1])
            begin
                overflow_next = 1'b1;
            end
            if (items.last_item)
            begin
                draining_next = 1'b1;
            end
        end
        if (out_accept && results.last_result)
        begin
            draining_next = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
        end
    end

    assign items.ready          = !draining_reg;
    assign results.valid        = draining_reg && cell_valid[0];
    assign results.sorted_value = cell_value[0];
    assign results.last_result  = !cell_valid[1];
    assign results.overflow     = overflow_reg;

endmodule

// ===== hw/rtl/iss_cell.sv =====
module iss_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  iss_pkg::iss_ctrl_t                ctrl,
    input  logic signed [iss_pkg::DATA_W-1:0] new_value,
    input  logic signed [iss_pkg::DATA_W-1:0] prev_value,
    input  logic                              prev_valid,
    input  logic                              prev_gt,
    input  logic signed [iss_pkg::DATA_W-1:0] next_value,
    input  logic                              next_valid,
    output logic signed [iss_pkg::DATA_W-1:0] value,
    output logic                              valid,
    output logic                              gt
);

    logic signed [iss_pkg::DATA_W-1:0] value_reg;
    logic signed [iss_pkg::DATA_W-1:0] value_next;
    logic                              valid_reg;
    logic                              valid_next;

    // An empty cell counts as greater, so a value larger than all stored ones lands in the first free cell.
    assign gt = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert && gt)
        begin
            if (prev_gt)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.drain)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== hw/rtl/iss_checker.sv =====
`include "insertion_sort_ascending_macros.svh"

module iss_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              in_last_item,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [iss_pkg::DATA_W-1:0] out_sorted_value,
    input logic                              out_last_result
);

    // No item is taken while a sorted run is being delivered.
    `ISS_ASSERT_SAME(a_no_input_during_run, clk, rst_n, out_valid, !in_ready)

    // A final item starts its run in the next cycle.
    `ISS_ASSERT_NEXT(a_run_follows_last, clk, rst_n,
                     in_valid && in_ready && in_last_item, out_valid)

    // After the final result is taken, the sorter is ready for a new list.
    `ISS_ASSERT_NEXT(a_ready_after_run, clk, rst_n,
                     out_valid && out_ready && out_last_result, !out_valid && in_ready)

    // A stalled result holds its value.
    `ISS_ASSERT_NEXT(a_stall_holds, clk, rst_n,
                     out_valid && !out_ready, out_valid && $stable(out_sorted_value))

endmodule

bind insertion_sort_ascending iss_checker u_iss_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (items.valid),
    .in_ready         (items.ready),
    .in_last_item     (items.last_item),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .out_sorted_value (results.sorted_value),
    .out_last_result  (results.last_result)
);

// ===== tb/sv/insertion_sort_ascending_checker.sv =====
module insertion_sort_ascending_checker
    import iss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    iss_in_if    items,
    iss_out_if   results,
    output int   fail_count,
    output int   pending_count,
    output int   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_result;
        logic                     overflow;
    } sort_result_t;

    logic signed [DATA_W-1:0] sorted_list[$];
    logic                     overflow_seen;
    sort_result_t             pending_sorted[$];

    function automatic void insert_sorted(input logic signed [DATA_W-1:0] v);
        int pos;
        pos = sorted_list.size();
        for (int i = 0; i < sorted_list.size(); i++)
        begin
            if (sorted_list[i] > v)
            begin
                pos = i;
                break;
            end
        end
        sorted_list.insert(pos, v);
    endfunction

    function automatic void take_item(input logic signed [DATA_W-1:0] v, input logic last);
        sort_result_t entry;
        if (sorted_list.size() < CAPACITY)
            insert_sorted(v);
        else
            overflow_seen = 1'b1;
        if (last)
        begin
            for (int k = 0; k < sorted_list.size(); k++)
            begin
                entry.sorted_value = sorted_list[k];
                entry.last_result  = (k == sorted_list.size() - 1);
                entry.overflow     = overflow_seen;
                pending_sorted.push_back(entry);
            end
            sorted_list.delete();
            overflow_seen = 1'b0;
        end
    endfunction

    function automatic void check_result();
        sort_result_t want;
        results_checked++;
        if (pending_sorted.size() == 0)
        begin
            $display("%0t ns: unexpected result, expected none, actual value %0d last %0b ovf %0b",
                     $time, results.sorted_value, results.last_result, results.overflow);
            fail_count++;
            return;
        end
        want = pending_sorted.pop_front();
        if (results.sorted_value !== want.sorted_value)
        begin
            $display("%0t ns: sorted_value expected %0d, actual %0d",
                     $time, want.sorted_value, results.sorted_value);
            fail_count++;
        end
        if (results.last_result !== want.last_result)
        begin
            $display("%0t ns: last_result expected %0b, actual %0b",
                     $time, want.last_result, results.last_result);
            fail_count++;
        end
        if (results.overflow !== want.overflow)
        begin
            $display("%0t ns: overflow expected %0b, actual %0b",
                     $time, want.overflow, results.overflow);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_list.delete();
            pending_sorted.delete();
            overflow_seen   = 1'b0;
            fail_count      = 0;
            pending_count   = 0;
            results_checked = 0;
        end
        else
        begin
            if (items.valid && items.ready)
                take_item(items.value, items.last_item);
            if (results.valid && results.ready)
                check_result();
            pending_count = pending_sorted.size();
        end
    end

endmodule

// ===== tb/sv/insertion_sort_ascending_tb.sv =====
module insertion_sort_ascending_tb;
    import iss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 230;
    localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

    logic clk;
    logic rst_n;

    iss_in_if  items_ch();
    iss_out_if results_ch();

    int fail_count;
    int pending_count;
    int results_checked;
    int items_sent;
    int lists_sent;
    int overflow_lists;
    int list_len;
    int burst_left;

    insertion_sort_ascending u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    insertion_sort_ascending_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .items           (items_ch),
        .results         (results_ch),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : result_ready_drive
        int   cycle;
        int   stall_mode;
        logic rdy;
        cycle      = 0;
        stall_mode = 0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = (cycle % 4 == 3);
                default: rdy = ($urandom_range(0, 9) == 0);
            endcase
            results_ch.ready <= rdy;
        end
    end

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            items_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
    endtask

    task automatic push_element(input logic signed [DATA_W-1:0] v, input logic last);
        pace();
        items_ch.valid     <= 1'b1;
        items_ch.value     <= v;
        items_ch.last_item <= last;
        do @(posedge clk); while (!items_ch.ready);
        @(negedge clk);
        items_sent++;
        list_len++;
        if (last)
        begin
            lists_sent++;
            if (list_len > CAPACITY)
                overflow_lists++;
            list_len = 0;
        end
    endtask

    task automatic wait_for_drain();
        items_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input int mode);
        case (mode)
            1: return $signed($urandom_range(0, 8)) - 4;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return MAX_VAL;
                    1:       return MIN_VAL;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            3: return $urandom_range(0, 1) ? MAX_VAL - $urandom_range(0, 3)
                                           : MIN_VAL + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_list();
        int len;
        int sel;
        int mode;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
        else if (sel == 1)
            len = CAPACITY;
        else
            len = $urandom_range(1, 12);
        mode = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
            push_element(pick_value(mode), i == len - 1);
    endtask

    initial
    begin
        items_ch.valid     = 1'b0;
        items_ch.value     = '0;
        items_ch.last_item = 1'b0;
        rst_n          = 1'b0;
        items_sent     = 0;
        lists_sent     = 0;
        overflow_lists = 0;
        list_len       = 0;
        burst_left     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_element(MAX_VAL, 1'b1);
        push_element(MIN_VAL, 1'b1);

        push_element(0, 1'b0);
        push_element(-1, 1'b0);
        push_element(1, 1'b0);
        push_element(MAX_VAL, 1'b0);
        push_element(MIN_VAL, 1'b1);

        // The final transaction arrives with the store full, so it is dropped.
        for (int i = 0; i < CAPACITY; i++)
            push_element(1000 - i * 100, 1'b0);
        push_element(-5000, 1'b1);
        wait_for_drain();

        while (items_sent < TOTAL_ITEMS)
        begin
            send_random_list();
            if (lists_sent == 15)
                wait_for_drain();
        end
        items_ch.valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d items in %0d lists, %0d of them overflowing the store.",
                 items_sent, lists_sent, overflow_lists);
        $display("Checked %0d sorted results with random stalls on both channels.",
                 results_checked);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
